>>> rtl/rpu_pkg.sv
`timescale 1ns / 1ps

package rpu_pkg;

   localparam int WORD_W     = 32;
   localparam int ANGLE_W    = 18;
   localparam int T_W        = 19;
   localparam int POSE_DEPTH = 12;
   localparam int WRK_DEPTH  = 21;
   localparam int POS_BASE   = 9;
   localparam int STEP_W     = 7;

   localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sh0001_0000;

   // command codes carried in tuser
   localparam logic [2:0] OP_ROT_PARENT  = 3'd0;
   localparam logic [2:0] OP_ROT_LOCAL   = 3'd1;
   localparam logic [2:0] OP_MOVE_LOCAL  = 3'd2;
   localparam logic [2:0] OP_MOVE_PARENT = 3'd3;
   localparam logic [2:0] OP_SET_POS     = 3'd4;
   localparam logic [2:0] OP_XFORM       = 3'd5;

   // scratch slots of the rotation build; the matrix itself follows at WRK_ROT
   localparam int WRK_NX_T = 0;
   localparam int WRK_NZ_T = 1;
   localparam int WRK_YY0  = 2;
   localparam int WRK_XX   = 3;
   localparam int WRK_XY   = 4;
   localparam int WRK_XZ   = 5;
   localparam int WRK_YY   = 6;
   localparam int WRK_YZ   = 7;
   localparam int WRK_ZZ   = 8;
   localparam int WRK_XS   = 9;
   localparam int WRK_YS   = 10;
   localparam int WRK_ZS   = 11;
   localparam int WRK_ROT  = 12;

   localparam int ROT_STEPS         = 30;
   localparam int LEN_ROT_PARENT    = 66;
   localparam int LEN_ROT_LOCAL     = 57;
   localparam int LEN_MOVE_LOCAL    = 12;
   localparam int LEN_MOVE_PARENT   = 6;
   localparam int LEN_SET_POS       = 3;
   localparam int LEN_XFORM         = 12;

   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_POSE,
      SRC_WRK,
      SRC_VEC,
      SRC_COS,
      SRC_SIN,
      SRC_T,
      SRC_ONE
   } src_type;

   typedef struct packed {
      logic       first;
      logic       neg;
      logic       last;
      logic       to_nxt;
      logic [4:0] dst_idx;
   } mac_ctl_type;

   typedef struct packed {
      src_type     a_src;
      logic [3:0]  a_idx;
      src_type     b_src;
      logic [4:0]  b_idx;
      mac_ctl_type ctl;
   } uop_type;

   typedef struct packed {
      logic                     valid;
      logic                     to_nxt;
      logic [4:0]               idx;
      logic signed [WORD_W-1:0] data;
   } wr_type;

   function automatic uop_type mk_uop(src_type as, int ai, src_type bs, int bi,
                                      logic first, logic neg, logic last,
                                      logic to_nxt, int di);
      uop_type u;
      u.a_src       = as;
      u.a_idx       = 4'(ai);
      u.b_src       = bs;
      u.b_idx       = 5'(bi);
      u.ctl.first   = first;
      u.ctl.neg     = neg;
      u.ctl.last    = last;
      u.ctl.to_nxt  = to_nxt;
      u.ctl.dst_idx = 5'(di);
      return u;
   endfunction

   // axis-angle build: twelve products, then nine two-term sums
   function automatic uop_type rot_uop(logic [4:0] s);
      uop_type    u;
      logic [3:0] k;
      int         t1;
      int         t2;
      logic       neg;
      logic       use_cos;
      k       = 4'((s - 5'd12) >> 1);
      t1      = 0;
      t2      = 0;
      neg     = 1'b0;
      use_cos = 1'b0;
      u       = mk_uop(SRC_ZERO, 0, SRC_ZERO, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      case (k)
         4'd0: begin t1 = WRK_XX; use_cos = 1'b1; end
         4'd1: begin t1 = WRK_XY; t2 = WRK_ZS; end
         4'd2: begin t1 = WRK_XZ; t2 = WRK_YS; neg = 1'b1; end
         4'd3: begin t1 = WRK_XY; t2 = WRK_ZS; neg = 1'b1; end
         4'd4: begin t1 = WRK_YY; use_cos = 1'b1; end
         4'd5: begin t1 = WRK_YZ; t2 = WRK_XS; end
         4'd6: begin t1 = WRK_XZ; t2 = WRK_YS; end
         4'd7: begin t1 = WRK_YZ; t2 = WRK_XS; neg = 1'b1; end
         4'd8: begin t1 = WRK_ZZ; use_cos = 1'b1; end
         default: ;
      endcase
      if (s < 5'd12) begin
         case (s)
            5'd0:  u = mk_uop(SRC_VEC, 0, SRC_T, 0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_NX_T);
            5'd1:  u = mk_uop(SRC_VEC, 2, SRC_T, 0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_NZ_T);
            5'd2:  u = mk_uop(SRC_VEC, 1, SRC_VEC, 1, 1'b1, 1'b0, 1'b1, 1'b0, WRK_YY0);
            5'd3:  u = mk_uop(SRC_VEC, 0, SRC_WRK, WRK_NX_T, 1'b1, 1'b0, 1'b1, 1'b0, WRK_XX);
            5'd4:  u = mk_uop(SRC_VEC, 1, SRC_WRK, WRK_NX_T, 1'b1, 1'b0, 1'b1, 1'b0, WRK_XY);
            5'd5:  u = mk_uop(SRC_VEC, 2, SRC_WRK, WRK_NX_T, 1'b1, 1'b0, 1'b1, 1'b0, WRK_XZ);
            5'd6:  u = mk_uop(SRC_T, 0, SRC_WRK, WRK_YY0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_YY);
            5'd7:  u = mk_uop(SRC_VEC, 1, SRC_WRK, WRK_NZ_T, 1'b1, 1'b0, 1'b1, 1'b0, WRK_YZ);
            5'd8:  u = mk_uop(SRC_VEC, 2, SRC_WRK, WRK_NZ_T, 1'b1, 1'b0, 1'b1, 1'b0, WRK_ZZ);
            5'd9:  u = mk_uop(SRC_VEC, 0, SRC_SIN, 0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_XS);
            5'd10: u = mk_uop(SRC_VEC, 1, SRC_SIN, 0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_YS);
            5'd11: u = mk_uop(SRC_VEC, 2, SRC_SIN, 0, 1'b1, 1'b0, 1'b1, 1'b0, WRK_ZS);
            default: ;
         endcase
      end else if (!s[0]) begin
         u = mk_uop(SRC_ONE, 0, SRC_WRK, t1, 1'b1, 1'b0, 1'b0, 1'b0, 0);
      end else if (use_cos) begin
         u = mk_uop(SRC_COS, 0, SRC_ONE, 0, 1'b0, 1'b0, 1'b1, 1'b0, WRK_ROT + int'(k));
      end else begin
         u = mk_uop(SRC_ONE, 0, SRC_WRK, t2, 1'b0, neg, 1'b1, 1'b0, WRK_ROT + int'(k));
      end
      return u;
   endfunction

   function automatic logic [STEP_W-1:0] prog_len(logic [2:0] op);
      logic [STEP_W-1:0] n;
      case (op)
         OP_ROT_PARENT:  n = STEP_W'(LEN_ROT_PARENT);
         OP_ROT_LOCAL:   n = STEP_W'(LEN_ROT_LOCAL);
         OP_MOVE_LOCAL:  n = STEP_W'(LEN_MOVE_LOCAL);
         OP_MOVE_PARENT: n = STEP_W'(LEN_MOVE_PARENT);
         OP_SET_POS:     n = STEP_W'(LEN_SET_POS);
         OP_XFORM:       n = STEP_W'(LEN_XFORM);
         default:        n = '0;
      endcase
      return n;
   endfunction

   // microcode for one command: each step is one product into the accumulator
   function automatic uop_type prog_uop(logic [2:0] op, logic [STEP_W-1:0] step);
      uop_type u;
      int      n;
      int      col;
      int      row;
      int      k;
      int      i;
      u = mk_uop(SRC_ZERO, 0, SRC_ZERO, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      n = 0;
      if (op == OP_ROT_PARENT || op == OP_ROT_LOCAL) begin
         if (step < STEP_W'(ROT_STEPS)) u = rot_uop(step[4:0]);
         n = ROT_STEPS;
         for (col = 0; col < 3; col++) begin
            for (row = 0; row < 3; row++) begin
               for (k = 0; k < 3; k++) begin
                  if (step == STEP_W'(n)) begin
                     if (op == OP_ROT_PARENT)
                        u = mk_uop(SRC_POSE, col*3 + k, SRC_WRK, WRK_ROT + k*3 + row,
                                   k == 0, 1'b0, k == 2, 1'b1, col*3 + row);
                     else
                        u = mk_uop(SRC_POSE, k*3 + row, SRC_WRK, WRK_ROT + col*3 + k,
                                   k == 0, 1'b0, k == 2, 1'b1, col*3 + row);
                  end
                  n++;
               end
            end
         end
         if (op == OP_ROT_PARENT) begin
            for (i = 0; i < 3; i++) begin
               for (k = 0; k < 3; k++) begin
                  if (step == STEP_W'(n))
                     u = mk_uop(SRC_POSE, POS_BASE + k, SRC_WRK, WRK_ROT + k*3 + i,
                                k == 0, 1'b0, k == 2, 1'b1, POS_BASE + i);
                  n++;
               end
            end
         end
      end else if (op == OP_MOVE_LOCAL || op == OP_XFORM) begin
         for (i = 0; i < 3; i++) begin
            if (step == STEP_W'(n)) begin
               if (op == OP_MOVE_LOCAL)
                  u = mk_uop(SRC_POSE, POS_BASE + i, SRC_ONE, 0,
                             1'b1, 1'b0, 1'b0, 1'b1, 0);
               else
                  u = mk_uop(SRC_POSE, POS_BASE + i, SRC_VEC, 3,
                             1'b1, 1'b0, 1'b0, 1'b1, 0);
            end
            n++;
            for (k = 0; k < 3; k++) begin
               if (step == STEP_W'(n))
                  u = mk_uop(SRC_POSE, k*3 + i, SRC_VEC, k,
                             1'b0, 1'b0, k == 2, 1'b1, POS_BASE + i);
               n++;
            end
         end
      end else if (op == OP_MOVE_PARENT) begin
         for (i = 0; i < 3; i++) begin
            if (step == STEP_W'(n))
               u = mk_uop(SRC_POSE, POS_BASE + i, SRC_ONE, 0, 1'b1, 1'b0, 1'b0, 1'b1, 0);
            n++;
            if (step == STEP_W'(n))
               u = mk_uop(SRC_ONE, 0, SRC_VEC, i, 1'b0, 1'b0, 1'b1, 1'b1, POS_BASE + i);
            n++;
         end
      end else if (op == OP_SET_POS) begin
         for (i = 0; i < 3; i++) begin
            if (step == STEP_W'(n))
               u = mk_uop(SRC_ONE, 0, SRC_VEC, i, 1'b1, 1'b0, 1'b1, 1'b1, POS_BASE + i);
            n++;
         end
      end
      return u;
   endfunction

endpackage

>>> rtl/rigid_pose_update_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Words                                   Side bits
// req      in   ax, ay, az, aw, cos_angle, sin_angle    tuser: opcode
// rsp      out  rx, ry, rz, rw                          none
//
// Steps: rotate parent 66, rotate local 57, move local 12, transform 12, move parent 6,
// set position 3, unused codes 0; one shared 32x32 multiplier runs one step a cycle.
// The response is registered once the last step has left the multiply, round and accumulate
// registers, or with no steps at all for unused codes; ready returns with it.
// Reset puts the pose back to identity with zero translation.
// A held response stalls only the finish of the next command, never its accept.

module rigid_pose_update_unit
   import rpu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // ax, ay, az, aw, cos_angle, sin_angle, zero pad
   input  logic [2:0]   req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata   // rx, ry, rz, rw
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FINISH
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic [STEP_W-1:0]        step_ff;
   logic [STEP_W-1:0]        len_ff;
   uop_type                  uop_ff;
   logic [2:0]               op_ff;
   logic                     rsp_tvalid_ff;
   logic [127:0]             rsp_tdata_ff;

   logic signed [WORD_W-1:0] ax_ff;
   logic signed [WORD_W-1:0] ay_ff;
   logic signed [WORD_W-1:0] az_ff;
   logic signed [WORD_W-1:0] aw_ff;
   logic signed [ANGLE_W-1:0] cos_ff;
   logic signed [ANGLE_W-1:0] sin_ff;
   logic signed [T_W-1:0]    t_ff;
   logic signed [ANGLE_W-1:0] req_cos;

   logic signed [WORD_W-1:0] pose_ff [POSE_DEPTH];
   logic signed [WORD_W-1:0] wrk_ff  [WRK_DEPTH];
   logic signed [WORD_W-1:0] nxt_ff  [POSE_DEPTH];

   logic                     accept;
   logic                     issue;
   logic                     finish;
   logic                     mac_busy;
   wr_type                   wr;
   logic signed [WORD_W-1:0] vec_a;
   logic signed [WORD_W-1:0] vec_b;
   logic signed [WORD_W-1:0] op_a;
   logic signed [WORD_W-1:0] op_b;
   logic                     commit_a;
   logic                     commit_p;
   logic signed [WORD_W-1:0] out_x;
   logic signed [WORD_W-1:0] out_y;
   logic signed [WORD_W-1:0] out_z;
   logic signed [WORD_W-1:0] out_w;

   assign req_cos    = req_tdata[145:128];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign issue      = (state_ff == S_RUN);
   assign finish     = (state_ff == S_FINISH) && !mac_busy && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = (prog_len(req_tuser) == '0) ? S_FINISH : S_RUN;
         S_RUN:    if (step_ff == len_ff - STEP_W'(1)) state_in = S_FINISH;
         S_FINISH: if (finish) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      commit_a = (op_ff == OP_ROT_PARENT) || (op_ff == OP_ROT_LOCAL);
      commit_p = (op_ff == OP_ROT_PARENT) || (op_ff == OP_MOVE_LOCAL) ||
                 (op_ff == OP_MOVE_PARENT) || (op_ff == OP_SET_POS);
      if (op_ff == OP_XFORM || commit_p) begin
         out_x = nxt_ff[POS_BASE];
         out_y = nxt_ff[POS_BASE + 1];
         out_z = nxt_ff[POS_BASE + 2];
      end else begin
         out_x = pose_ff[POS_BASE];
         out_y = pose_ff[POS_BASE + 1];
         out_z = pose_ff[POS_BASE + 2];
      end
      out_w = (op_ff == OP_XFORM) ? aw_ff : ONE_Q16;
   end

   // sequencer: microcode is fetched one step ahead of issue
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish)
            rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid_ff <= 1'b0;
         if (accept) begin
            step_ff <= '0;
            len_ff  <= prog_len(req_tuser);
            op_ff   <= req_tuser;
            uop_ff  <= prog_uop(req_tuser, '0);
         end else if (issue) begin
            step_ff <= step_ff + STEP_W'(1);
            uop_ff  <= prog_uop(op_ff, step_ff + STEP_W'(1));
         end
         if (finish) rsp_tdata_ff <= {out_w, out_z, out_y, out_x};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff  <= req_tdata[31:0];
         ay_ff  <= req_tdata[63:32];
         az_ff  <= req_tdata[95:64];
         aw_ff  <= req_tdata[127:96];
         cos_ff <= req_cos;
         sin_ff <= req_tdata[163:146];
         t_ff   <= 19'sd65536 - T_W'(req_cos);
      end
      if (wr.valid) begin
         if (wr.to_nxt)
            nxt_ff[wr.idx[3:0]] <= wr.data;
         else
            wrk_ff[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POSE_DEPTH; i++)
            pose_ff[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q16 : '0;
      end else if (finish) begin
         for (int i = 0; i < POSE_DEPTH; i++) begin
            if ((i < POS_BASE && commit_a) || (i >= POS_BASE && commit_p))
               pose_ff[i] <= nxt_ff[i];
         end
      end
   end

   always_comb begin
      unique case (uop_ff.a_idx[1:0])
         2'd0: vec_a = ax_ff;
         2'd1: vec_a = ay_ff;
         2'd2: vec_a = az_ff;
         2'd3: vec_a = aw_ff;
      endcase
      unique case (uop_ff.b_idx[1:0])
         2'd0: vec_b = ax_ff;
         2'd1: vec_b = ay_ff;
         2'd2: vec_b = az_ff;
         2'd3: vec_b = aw_ff;
      endcase
   end

   always_comb begin
      unique case (uop_ff.a_src)
         SRC_POSE: op_a = pose_ff[uop_ff.a_idx];
         SRC_VEC:  op_a = vec_a;
         SRC_COS:  op_a = WORD_W'(cos_ff);
         SRC_SIN:  op_a = WORD_W'(sin_ff);
         SRC_T:    op_a = WORD_W'(t_ff);
         SRC_ONE:  op_a = ONE_Q16;
         default:  op_a = '0;
      endcase
      unique case (uop_ff.b_src)
         SRC_WRK:  op_b = wrk_ff[uop_ff.b_idx];
         SRC_VEC:  op_b = vec_b;
         SRC_COS:  op_b = WORD_W'(cos_ff);
         SRC_SIN:  op_b = WORD_W'(sin_ff);
         SRC_T:    op_b = WORD_W'(t_ff);
         SRC_ONE:  op_b = ONE_Q16;
         default:  op_b = '0;
      endcase
   end

   rpu_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .op_a  (op_a),
      .op_b  (op_b),
      .ctl   (uop_ff.ctl),
      .busy  (mac_busy),
      .wr    (wr)
   );

endmodule

>>> rtl/rpu_mac.sv
`timescale 1ns / 1ps

module rpu_mac
   import rpu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  logic signed [WORD_W-1:0] op_a,
   input  logic signed [WORD_W-1:0] op_b,
   input  mac_ctl_type              ctl,
   output logic                     busy,
   output wr_type                   wr
);

   logic signed [63:0]       prod_ff;
   mac_ctl_type              ctl1_ff;
   logic                     v1_ff;
   logic signed [WORD_W-1:0] q_ff;
   logic signed [WORD_W-1:0] q_in;
   mac_ctl_type              ctl2_ff;
   logic                     v2_ff;
   logic signed [34:0]       acc_ff;
   logic signed [34:0]       acc_in;
   logic signed [63:0]       rnd;
   logic signed [47:0]       shifted;
   logic signed [34:0]       term;

   // round half up to Q16.16, then clamp to 32 bits
   always_comb begin
      rnd     = prod_ff + 64'sd32768;
      shifted = rnd[63:16];
      if (shifted > 48'sd2147483647)
         q_in = 32'sh7FFF_FFFF;
      else if (shifted < -48'sd2147483648)
         q_in = 32'sh8000_0000;
      else
         q_in = shifted[31:0];
   end

   always_comb begin
      term   = ctl2_ff.neg ? -35'(q_ff) : 35'(q_ff);
      acc_in = (ctl2_ff.first ? 35'sd0 : acc_ff) + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
      prod_ff <= op_a * op_b;
      ctl1_ff <= ctl;
      q_ff    <= q_in;
      ctl2_ff <= ctl1_ff;
      if (v2_ff) acc_ff <= acc_in;
   end

   assign busy = v1_ff | v2_ff;

   always_comb begin
      wr.valid  = v2_ff & ctl2_ff.last;
      wr.to_nxt = ctl2_ff.to_nxt;
      wr.idx    = ctl2_ff.dst_idx;
      if (acc_in > 35'sd2147483647)
         wr.data = 32'sh7FFF_FFFF;
      else if (acc_in < -35'sd2147483648)
         wr.data = 32'sh8000_0000;
      else
         wr.data = acc_in[31:0];
   end

endmodule

>>> rtl/rpu_checker.sv
`timescale 1ns / 1ps

module rpu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // reset leaves the block ready with no word pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // one command at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready held through an accepted command");

   // ready drops only because a command was taken
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(req_tready) |-> $past(req_tvalid))
      else $error("ready dropped without a command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

endmodule

bind rigid_pose_update_unit rpu_checker u_checker (.*);

>>> tb/rigid_pose_update_unit_tb.sv
`timescale 1ns / 1ps

module rigid_pose_update_unit_tb
   import rpu_pkg::*;
();

   // codes the block leaves unused
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int Q_MAX = 32'sh7fff_ffff;
   localparam int Q_MIN = 32'sh8000_0000;
   localparam int Q_ONE = 65536;
   localparam int RANDOM_CMDS = 925;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] aw;
      logic signed [17:0] cos_angle;
      logic signed [17:0] sin_angle;
   } pose_cmd_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] rw;
   } pose_vec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;  // ax, ay, az, aw, cos_angle, sin_angle, zero pad
   logic [2:0]   req_tuser = '0;  // opcode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // rx, ry, rz, rw

   pose_cmd_type pending_cmds [$];
   pose_vec_type expected_vecs [$];
   logic signed [31:0] pose_words [12];
   logic signed [31:0] turn_words [9];
   logic signed [31:0] mat_next [9];
   logic        req_fire = 1'b0;
   int unsigned cycle_count = 0;
   int          err_count = 0;

   rigid_pose_update_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- arithmetic

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[31:0];
   endfunction

   // round half up, then saturate
   function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return clamp32(p >>> 16);
   endfunction

   task automatic build_turn(input logic signed [31:0] nx, input logic signed [31:0] ny,
                             input logic signed [31:0] nz, input logic signed [31:0] c,
                             input logic signed [31:0] s);
      logic signed [31:0] t, nxt, nzt, xx, xy, xz, yy, yz, zz, xs, ys, zs;
      t   = clamp32(longint'(Q_ONE) - longint'(c));
      nxt = qmul(nx, t);
      nzt = qmul(nz, t);
      xx  = qmul(nx, nxt);
      xy  = qmul(ny, nxt);
      xz  = qmul(nz, nxt);
      yy  = qmul(qmul(ny, ny), t);
      yz  = qmul(ny, nzt);
      zz  = qmul(nz, nzt);
      xs  = qmul(nx, s);
      ys  = qmul(ny, s);
      zs  = qmul(nz, s);
      turn_words[0] = clamp32(longint'(xx) + longint'(c));
      turn_words[1] = clamp32(longint'(xy) + longint'(zs));
      turn_words[2] = clamp32(longint'(xz) - longint'(ys));
      turn_words[3] = clamp32(longint'(xy) - longint'(zs));
      turn_words[4] = clamp32(longint'(yy) + longint'(c));
      turn_words[5] = clamp32(longint'(yz) + longint'(xs));
      turn_words[6] = clamp32(longint'(xz) + longint'(ys));
      turn_words[7] = clamp32(longint'(yz) - longint'(xs));
      turn_words[8] = clamp32(longint'(zz) + longint'(c));
   endtask

   // advance the pose by one command and return the vector it answers with
   task automatic predict_pose(input pose_cmd_type cmd, output pose_vec_type res);
      logic signed [31:0] v [3];
      logic signed [31:0] pos_new [3];
      logic signed [31:0] c, s;
      longint acc;
      int col, row, k;
      v[0] = cmd.ax;
      v[1] = cmd.ay;
      v[2] = cmd.az;
      c = cmd.cos_angle;
      s = cmd.sin_angle;
      res.rw = Q_ONE;
      case (cmd.opcode)
         OP_ROT_PARENT, OP_ROT_LOCAL: begin
            build_turn(v[0], v[1], v[2], c, s);
            for (col = 0; col < 3; col++) begin
               for (row = 0; row < 3; row++) begin
                  acc = 0;
                  for (k = 0; k < 3; k++) begin
                     if (cmd.opcode == OP_ROT_PARENT)
                        acc += qmul(turn_words[k*3 + row], pose_words[col*3 + k]);
                     else
                        acc += qmul(pose_words[k*3 + row], turn_words[col*3 + k]);
                  end
                  mat_next[col*3 + row] = clamp32(acc);
               end
            end
            if (cmd.opcode == OP_ROT_PARENT) begin
               for (row = 0; row < 3; row++) begin
                  acc = 0;
                  for (k = 0; k < 3; k++)
                     acc += qmul(turn_words[k*3 + row], pose_words[POS_BASE + k]);
                  pos_new[row] = clamp32(acc);
               end
               for (row = 0; row < 3; row++) pose_words[POS_BASE + row] = pos_new[row];
            end
            for (k = 0; k < 9; k++) pose_words[k] = mat_next[k];
         end
         OP_MOVE_LOCAL: begin
            for (row = 0; row < 3; row++) begin
               acc = pose_words[POS_BASE + row];
               for (k = 0; k < 3; k++) acc += qmul(pose_words[k*3 + row], v[k]);
               pos_new[row] = clamp32(acc);
            end
            for (row = 0; row < 3; row++) pose_words[POS_BASE + row] = pos_new[row];
         end
         OP_MOVE_PARENT: begin
            for (row = 0; row < 3; row++)
               pose_words[POS_BASE + row] =
                  clamp32(longint'(pose_words[POS_BASE + row]) + longint'(v[row]));
         end
         OP_SET_POS: begin
            for (row = 0; row < 3; row++) pose_words[POS_BASE + row] = v[row];
         end
         default: ;
      endcase
      if (cmd.opcode == OP_XFORM) begin
         for (row = 0; row < 3; row++) begin
            acc = qmul(pose_words[POS_BASE + row], cmd.aw);
            for (k = 0; k < 3; k++) acc += qmul(pose_words[k*3 + row], v[k]);
            pos_new[row] = clamp32(acc);
         end
         res.rw = cmd.aw;
      end else begin
         for (row = 0; row < 3; row++) pos_new[row] = pose_words[POS_BASE + row];
      end
      res.rx = pos_new[0];
      res.ry = pos_new[1];
      res.rz = pos_new[2];
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int spread(int half);
      return int'($urandom_range(0, 2*half)) - half;
   endfunction

   function automatic int any_trig();
      return int'($urandom_range(0, 2*Q_ONE)) - Q_ONE;
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input int x, input int y, input int z,
                            input int w, input int c, input int s);
      pose_cmd_type cmd;
      cmd.opcode    = op;
      cmd.ax        = x;
      cmd.ay        = y;
      cmd.az        = z;
      cmd.aw        = w;
      cmd.cos_angle = 18'(c);
      cmd.sin_angle = 18'(s);
      pending_cmds.push_back(cmd);
   endtask

   // unit axis and a consistent cos/sin pair; sometimes an exact multiple of a right angle
   task automatic queue_turn(input logic [2:0] op);
      real x, y, z, len, ang;
      int  c, s;
      x = $urandom_range(0, 2000) / 1000.0 - 1.0;
      y = $urandom_range(0, 2000) / 1000.0 - 1.0;
      z = $urandom_range(0, 2000) / 1000.0 - 1.0;
      len = $sqrt(x*x + y*y + z*z);
      if (len < 0.1) begin
         x = 0.0;
         y = 0.0;
         z = 1.0;
         len = 1.0;
      end
      ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      c = $rtoi($cos(ang) * 65536.0);
      s = $rtoi($sin(ang) * 65536.0);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: begin c = Q_ONE;  s = 0;      end
            1: begin c = 0;      s = Q_ONE;  end
            2: begin c = -Q_ONE; s = 0;      end
            default: begin c = 0; s = -Q_ONE; end
         endcase
      end
      queue_cmd(op, $rtoi(x / len * 65536.0), $rtoi(y / len * 65536.0),
                $rtoi(z / len * 65536.0), $urandom, c, s);
   endtask

   task automatic queue_random_cmds();
      int n, roll, w;
      for (n = 0; n < RANDOM_CMDS; n++) begin
         roll = $urandom_range(0, 99);
         if (n > RANDOM_CMDS - 90) begin
            // raw noise last: a wild rotation wrecks the pose for good
            queue_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                      any_trig(), any_trig());
         end else if (roll < 20) begin
            queue_turn(OP_ROT_PARENT);
         end else if (roll < 38) begin
            queue_turn(OP_ROT_LOCAL);
         end else if (roll < 52) begin
            queue_cmd(OP_MOVE_LOCAL, spread(1 << 20), spread(1 << 20), spread(1 << 20),
                      $urandom, any_trig(), any_trig());
         end else if (roll < 64) begin
            queue_cmd(OP_MOVE_PARENT, spread(1 << 20), spread(1 << 20), spread(1 << 20),
                      $urandom, any_trig(), any_trig());
         end else if (roll < 72) begin
            queue_cmd(OP_SET_POS, spread(1 << 22), spread(1 << 22), spread(1 << 22),
                      $urandom, any_trig(), any_trig());
         end else if (roll < 94) begin
            w = ($urandom_range(0, 2) == 0) ? spread(1 << 18) : Q_ONE;
            queue_cmd(OP_XFORM, spread(1 << 22), spread(1 << 22), spread(1 << 22), w,
                      any_trig(), any_trig());
         end else if (roll < 97) begin
            queue_cmd(OP_XFORM, $urandom, $urandom, $urandom, $urandom,
                      any_trig(), any_trig());
         end else if (roll < 98) begin
            queue_cmd(($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7,
                      $urandom, $urandom, $urandom, $urandom, any_trig(), any_trig());
         end else begin
            // saturate the position, later set-position commands recover it
            queue_cmd(($urandom_range(0, 1) != 0) ? OP_SET_POS : OP_MOVE_PARENT,
                      $urandom, $urandom, $urandom, $urandom, any_trig(), any_trig());
         end
      end
   endtask

   // ---------------------------------------------------------------- drive and check

   // random idling on either side, apart from a quiet stretch with none
   function automatic bit take_break();
      if (cycle_count >= 25000 && cycle_count < 40000) return 1'b0;
      return $urandom_range(0, 99) < 12;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_word(input string name, input logic [31:0] got,
                             input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   always @(negedge clock) begin : drive
      pose_cmd_type cmd;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (!req_tvalid || req_fire) begin
            if (pending_cmds.size() != 0 && !take_break()) begin
               cmd = pending_cmds.pop_front();
               req_tdata  <= {4'b0, cmd.sin_angle, cmd.cos_angle, cmd.aw, cmd.az,
                              cmd.ay, cmd.ax};
               req_tuser  <= cmd.opcode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !take_break();
      end
   end

   always @(posedge clock) begin : watch
      pose_cmd_type cmd;
      pose_vec_type got;
      pose_vec_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         // check the response before queuing the new word's expectation
         if (rsp_tvalid && rsp_tready) begin
            got.rx = rsp_tdata[31:0];
            got.ry = rsp_tdata[63:32];
            got.rz = rsp_tdata[95:64];
            got.rw = rsp_tdata[127:96];
            if (expected_vecs.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing outstanding", rsp_tdata));
            end else begin
               want = expected_vecs.pop_front();
               check_word("rx", got.rx, want.rx);
               check_word("ry", got.ry, want.ry);
               check_word("rz", got.rz, want.rz);
               check_word("rw", got.rw, want.rw);
            end
         end
         if (req_tvalid && req_tready) begin
            cmd.opcode    = req_tuser;
            cmd.ax        = req_tdata[31:0];
            cmd.ay        = req_tdata[63:32];
            cmd.az        = req_tdata[95:64];
            cmd.aw        = req_tdata[127:96];
            cmd.cos_angle = req_tdata[145:128];
            cmd.sin_angle = req_tdata[163:146];
            predict_pose(cmd, want);
            expected_vecs.push_back(want);
         end
      end
   end

   initial begin : run
      int i;
      for (i = 0; i < 12; i++) pose_words[i] = 0;
      pose_words[0] = ONE_Q16;
      pose_words[4] = ONE_Q16;
      pose_words[8] = ONE_Q16;

      // directed: identity, extremes, each command, degenerate rotations
      queue_cmd(OP_XFORM, Q_ONE, 2*Q_ONE, 3*Q_ONE, Q_ONE, 0, 0);
      queue_cmd(OP_SET_POS, Q_MAX, Q_MIN, 0, 0, 0, 0);
      queue_cmd(OP_MOVE_PARENT, Q_MAX, Q_MAX, Q_MIN, 0, 0, 0);
      queue_cmd(OP_MOVE_PARENT, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0);
      queue_cmd(OP_SET_POS, Q_ONE, 2*Q_ONE, 3*Q_ONE, 0, 0, 0);
      queue_cmd(OP_ROT_PARENT, 0, 0, Q_ONE, 0, 0, Q_ONE);
      queue_cmd(OP_ROT_LOCAL, Q_ONE, 0, 0, 0, 0, Q_ONE);
      queue_cmd(OP_MOVE_LOCAL, Q_ONE, 0, 0, 0, 0, 0);
      queue_cmd(OP_XFORM, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 0, 0);
      queue_cmd(OP_XFORM, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0);
      queue_cmd(OP_XFORM, 5*Q_ONE, -7*Q_ONE, Q_ONE, 0, 0, 0);
      queue_cmd(OP_ROT_PARENT, Q_ONE, 0, 0, -1, -Q_ONE, 0);
      queue_cmd(OP_ROT_LOCAL, 0, Q_ONE, 0, Q_MAX, 0, -Q_ONE);
      // axis not always unit, cos and sin not consistent
      queue_cmd(OP_ROT_PARENT, Q_ONE, Q_ONE, 0, 0, Q_ONE, Q_ONE / 2);
      queue_cmd(OP_ROT_LOCAL, 0, 0, Q_ONE, 0, Q_ONE, Q_ONE);
      queue_cmd(OP_SPARE_6, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_ONE, -Q_ONE);
      queue_cmd(OP_SPARE_7, -1, -1, -1, -1, -Q_ONE, Q_ONE);
      queue_cmd(OP_MOVE_LOCAL, Q_MAX, Q_MIN, 0, 0, 0, 0);
      queue_cmd(OP_SET_POS, 0, 0, 0, Q_MIN, -Q_ONE, -Q_ONE);
      queue_cmd(OP_XFORM, 0, 0, 0, Q_ONE, 0, 0);
      queue_random_cmds();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_vecs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/rpu_pkg.sv
rtl/rpu_mac.sv
rtl/rigid_pose_update_unit.sv
rtl/rpu_checker.sv
tb/rigid_pose_update_unit_tb.sv
